// File: rtl/tcp_flow_tracking_table_assert.svh
// ----------------------------------------------------------------------------
// tcp_flow_tracking_table_assert.svh
// Assertion macros for the flow tracking table. Each macro expects clk and
// arst_n in scope and checks only while out of reset.
// ----------------------------------------------------------------------------
`ifndef TCP_FLOW_TRACKING_TABLE_ASSERT_SVH
`define TCP_FLOW_TRACKING_TABLE_ASSERT_SVH

// Same-cycle implication
`define TFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Plain invariant, built on the same-cycle form
`define TFT_ASSERT_ALWAYS(lbl, cond, msg) \
	`TFT_ASSERT_NOW(lbl, 1'b1, cond, msg)

`endif

// File: rtl/tft_pkg.sv
// ----------------------------------------------------------------------------
// tft_pkg
// Shared types and constants of the TCP flow tracking table: table entry
// layout, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tft_pkg;

	// Default number of table slots
	localparam int unsigned TFT_TABLE_DEPTH = 64;
	// Width of the reported slot number
	localparam int unsigned TFT_SLOT_W = 6;

	// One table entry as stored in the memory
	typedef struct packed {
		logic        valid;
		logic [63:0] address_pair;
		logic [31:0] port_pair;
		logic [31:0] initial_seq;
		logic        fin_seen;
	} entry_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_WRITE,
		ST_WRITE_REV,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic scan;
		logic write_slot;
		logic write_rev;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cnt_last;
		logic rev_needed;
		logic out_ready;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/tft_ctrl.sv
// ----------------------------------------------------------------------------
// tft_ctrl
// Sequencer of the flow table: clearing pass after reset, table scan,
// write-back of the flow slot and the reverse slot, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_ctrl import tft_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          hdr_valid,
	output logic         hdr_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		hdr_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.cnt_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				hdr_stall = 1'b0;
				if (hdr_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.cnt_last) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST: begin
				// last read word is compared in this cycle
				state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write_slot = 1'b1;
				state_nxt = status.rev_needed ? ST_WRITE_REV : ST_EMIT;
			end
			ST_WRITE_REV: begin
				cmd.write_rev = 1'b1;
				state_nxt     = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/tft_datapath.sv
// ----------------------------------------------------------------------------
// tft_datapath
// Flow table memory, scan counter, tuple compare, result logic and the
// output register of the TCP flow tracking table.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_datapath import tft_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TFT_TABLE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire cmd_t             cmd,
	output status_t               status,
	input  wire  [31:0]           src_address,
	input  wire  [31:0]           dst_address,
	input  wire  [15:0]           src_port,
	input  wire  [15:0]           dst_port,
	input  wire  [31:0]           seq_number,
	input  wire                   rst_flag,
	input  wire                   fin_flag,
	input  wire  [15:0]           payload_length,
	input  wire                   res_stall,
	output logic                  res_valid,
	output logic                  new_flow,
	output logic [TFT_SLOT_W-1:0] slot_index,
	output logic                  table_full,
	output logic                  flow_reset,
	output logic                  reverse_freed,
	output logic                  offset_valid,
	output logic [31:0]           stream_offset,
	output logic                  flow_closed
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned EXT_W = (IDX_W > TFT_SLOT_W) ? IDX_W : TFT_SLOT_W;

	// Captured header
	logic [63:0] addr_pair_q;
	logic [31:0] port_pair_q;
	logic [31:0] seq_q;
	logic        rst_q;
	logic        fin_q;
	logic        plen_nz_q;

	// Scan state
	logic [IDX_W-1:0] cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_s1;

	// Search results
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [31:0]      hit_iseq_q;
	logic             hit_fin_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             rev_q;
	logic [IDX_W-1:0] rev_idx_q;

	// Table memory
	entry_t mem [TABLE_DEPTH];

	logic             cnt_last;
	logic             fwd_match;
	logic             rev_match;
	logic             self_rev;
	logic             slot_found;
	logic [IDX_W-1:0] slot;
	logic [EXT_W-1:0] slot_ext;
	logic [31:0]      iseq;
	logic             fin_now;
	logic             new_flow_c;
	logic             table_full_c;
	logic             flow_reset_c;
	logic             rev_freed_c;
	logic             offset_valid_c;
	logic             flow_closed_c;
	logic             slot_wr_ok;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;
	logic             out_ready;

	assign cnt_last = (cnt_q == IDX_W'(TABLE_DEPTH - 1));

	// Latch the header on acceptance
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_pair_q <= {src_address, dst_address};
			port_pair_q <= {src_port, dst_port};
			seq_q       <= seq_number;
			rst_q       <= rst_flag;
			fin_q       <= fin_flag;
			plen_nz_q   <= (payload_length != 16'd0);
		end
	end

	// Advance the slot counter during clearing and scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.capture) begin
			cnt_q <= '0;
		end else if (cmd.clear || cmd.scan) begin
			cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
		end
	end

	// Registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_s1  <= mem[cnt_q];
			idx_s1 <= cnt_q;
		end
	end

	// Compare the read entry against the forward and reverse tuples
	assign fwd_match = rd_s1.valid && (rd_s1.address_pair == addr_pair_q) &&
	                   (rd_s1.port_pair == port_pair_q);
	assign rev_match = rd_s1.valid &&
	                   (rd_s1.address_pair == {addr_pair_q[31:0], addr_pair_q[63:32]}) &&
	                   (rd_s1.port_pair == {port_pair_q[15:0], port_pair_q[31:16]});

	// Keep the lowest hit, free slot and reverse hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			rev_q  <= 1'b0;
		end else if (cmd.capture) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			rev_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (fwd_match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!rd_s1.valid && !free_q) begin
				free_q <= 1'b1;
			end
			if (rev_match && !rev_q) begin
				rev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (fwd_match && !hit_q) begin
				hit_idx_q  <= idx_s1;
				hit_iseq_q <= rd_s1.initial_seq;
				hit_fin_q  <= rd_s1.fin_seen;
			end
			if (!rd_s1.valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (rev_match && !rev_q) begin
				rev_idx_q <= idx_s1;
			end
		end
	end

	// Resolve the transaction result from the search
	assign self_rev       = (addr_pair_q[63:32] == addr_pair_q[31:0]) &&
	                        (port_pair_q[31:16] == port_pair_q[15:0]);
	assign slot_found     = hit_q || free_q;
	assign slot           = hit_q ? hit_idx_q : free_idx_q;
	assign slot_ext       = EXT_W'(slot);
	assign iseq           = hit_q ? hit_iseq_q : seq_q;
	assign fin_now        = (hit_q && hit_fin_q) || fin_q;
	assign new_flow_c     = !hit_q && free_q;
	assign table_full_c   = !hit_q && !free_q;
	assign flow_reset_c   = slot_found && rst_q;
	// a tuple that is its own reverse was freed already
	assign rev_freed_c    = flow_reset_c && rev_q && !self_rev;
	assign offset_valid_c = slot_found && !rst_q && plen_nz_q;
	assign flow_closed_c  = slot_found && !rst_q && fin_now;
	// a new flow that is reset at once never reaches the table
	assign slot_wr_ok     = slot_found && !(new_flow_c && rst_q);

	// Single write port: clear, slot update or reverse free
	always_comb begin
		mem_wd.valid        = 1'b0;
		mem_wd.address_pair = addr_pair_q;
		mem_wd.port_pair    = port_pair_q;
		mem_wd.initial_seq  = iseq;
		mem_wd.fin_seen     = fin_now;
		mem_we              = 1'b0;
		mem_wa              = slot;
		if (cmd.clear) begin
			mem_we = 1'b1;
			mem_wa = cnt_q;
		end else if (cmd.write_slot) begin
			mem_we       = slot_wr_ok;
			mem_wd.valid = !rst_q;
		end else if (cmd.write_rev) begin
			mem_we = rev_freed_c;
			mem_wa = rev_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Output register
	assign out_ready = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.emit) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			new_flow      <= new_flow_c;
			slot_index    <= slot_found ? slot_ext[TFT_SLOT_W-1:0] : '0;
			table_full    <= table_full_c;
			flow_reset    <= flow_reset_c;
			reverse_freed <= rev_freed_c;
			offset_valid  <= offset_valid_c;
			stream_offset <= offset_valid_c ? (seq_q - iseq) : 32'd0;
			flow_closed   <= flow_closed_c;
		end
	end

	assign status.cnt_last   = cnt_last;
	assign status.rev_needed = rev_freed_c;
	assign status.out_ready  = out_ready;

endmodule

`default_nettype wire

// File: rtl/tcp_flow_tracking_table.sv
// ----------------------------------------------------------------------------
// tcp_flow_tracking_table: each header goes through a table scan, the
// write-back of its slot (and of the reverse slot when an RST also frees the
// reverse flow) and the output register. The scan reads one table entry per
// cycle through the single read port; a new header is accepted only once the
// last result has entered the output register. Reset: asynchronous, active
// low; a clearing pass over every slot follows, during which no header is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_flow_tracking_table_assert.svh"

module tcp_flow_tracking_table import tft_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TFT_TABLE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   hdr_valid,
	output logic                  hdr_stall,
	input  wire  [31:0]           src_address,
	input  wire  [31:0]           dst_address,
	input  wire  [15:0]           src_port,
	input  wire  [15:0]           dst_port,
	input  wire  [31:0]           seq_number,
	input  wire                   rst_flag,
	input  wire                   fin_flag,
	input  wire  [15:0]           payload_length,
	output logic                  res_valid,
	input  wire                   res_stall,
	output logic                  new_flow,
	output logic [TFT_SLOT_W-1:0] slot_index,
	output logic                  table_full,
	output logic                  flow_reset,
	output logic                  reverse_freed,
	output logic                  offset_valid,
	output logic [31:0]           stream_offset,
	output logic                  flow_closed
);

	cmd_t    cmd;
	status_t status;

	// Sequencer
	tft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_stall (hdr_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Table and result datapath
	tft_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.src_address    (src_address),
		.dst_address    (dst_address),
		.src_port       (src_port),
		.dst_port       (dst_port),
		.seq_number     (seq_number),
		.rst_flag       (rst_flag),
		.fin_flag       (fin_flag),
		.payload_length (payload_length),
		.res_stall      (res_stall),
		.res_valid      (res_valid),
		.new_flow       (new_flow),
		.slot_index     (slot_index),
		.table_full     (table_full),
		.flow_reset     (flow_reset),
		.reverse_freed  (reverse_freed),
		.offset_valid   (offset_valid),
		.stream_offset  (stream_offset),
		.flow_closed    (flow_closed)
	);

	// Block checks
	`TFT_ASSERT_NEXT(a_busy_after_accept, hdr_valid && !hdr_stall, hdr_stall, "accepted header did not make the block busy")
	`TFT_ASSERT_ALWAYS(a_one_command, $onehot0(cmd), "more than one datapath command at once")
	`TFT_ASSERT_NOW(a_new_xor_full, res_valid, !(new_flow && table_full), "result flags both a new flow and a full table")
	`TFT_ASSERT_NOW(a_reset_clean, res_valid && flow_reset, !offset_valid && !flow_closed, "reset transaction reports an offset or a close")

endmodule

`default_nettype wire
